### src/hpc_pkg.sv
// Shared types and constants for the heater time-proportional controller.
package hpc_pkg;

   localparam int TEMP_W  = 12;
   localparam int RISE_W  = 11;
   localparam int CFG_W   = 8;
   localparam int GAIN_W  = 8;
   localparam int PULSE_W = 16;
   localparam int SEC_W   = 5;
   localparam int E_W     = 14;   // 10*(offset+setpoint) - temperature
   localparam int D_W     = 12;   // clamped drive, at most 10*setpoint
   localparam int MAW     = 20;   // wide multiplier operand

   typedef logic [2:0] csr_index_type;
   localparam csr_index_type CSR_SETPOINT      = 3'd0;
   localparam csr_index_type CSR_OFFSET        = 3'd1;
   localparam csr_index_type CSR_INITIAL_GAIN  = 3'd2;
   localparam csr_index_type CSR_FALLBACK_GAIN = 3'd3;
   localparam csr_index_type CSR_CYCLE_SECONDS = 3'd4;

   localparam logic [GAIN_W-1:0] GAIN_RESET     = 8'd25;
   localparam logic [GAIN_W-1:0] FALLBACK_RESET = 8'd20;
   localparam logic [CFG_W-1:0]  CYCLE_RESET    = 8'd10;
   localparam logic [GAIN_W:0]   GAIN_INC       = 9'd2;
   localparam logic [GAIN_W-1:0] GAIN_MAX       = 8'd255;

   localparam logic [SEC_W-1:0] GAIN_STEP_SECONDS = 5'd20;
   localparam logic [SEC_W-1:0] SEC_MAX           = 5'd31;

   localparam logic signed [E_W-1:0]    E_STEP_LO   = 14'sd9;
   localparam logic signed [E_W-1:0]    E_STEP_HI   = 14'sd150;
   localparam logic signed [E_W-1:0]    E_OVERSHOOT = -14'sd3;
   localparam logic signed [RISE_W-1:0] RISE_STEP   = 11'sd3;
   localparam int PULSE_STEP_SECONDS = 9;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GAIN,
      ST_MUL_EG,
      ST_CLAMP,
      ST_MUL_DC,
      ST_MUL_DT,
      ST_LOAD,
      ST_DIV,
      ST_PULSE,
      ST_FIN
   } state_type;

   typedef enum logic [1:0] {
      MDU_HOLD,
      MDU_MUL,
      MDU_LOAD,
      MDU_STEP
   } mdu_op_type;

endpackage

### src/hpc_ifs.sv
// Handshake channel interfaces: tick requests, results and register writes.
interface hpc_req_if import hpc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [TEMP_W-1:0] temperature_tenths;
   logic signed [RISE_W-1:0] rise_tenths;
   logic                     enable;

   modport source (output valid, temperature_tenths, rise_tenths, enable, input ready);
   modport sink   (input valid, temperature_tenths, rise_tenths, enable, output ready);
endinterface

interface hpc_rsp_if import hpc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               heater_on;
   logic [PULSE_W-1:0] on_ticks;
   logic [GAIN_W-1:0]  gain_now;

   modport source (output valid, heater_on, on_ticks, gain_now, input ready);
   modport sink   (input valid, heater_on, on_ticks, gain_now, output ready);
endinterface

interface hpc_csr_if import hpc_pkg::*; ();
   logic              valid;
   logic              ready;
   csr_index_type     index;
   logic [CFG_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### src/heater_time_proportional_control.sv
// Heater time-proportional control: one result word per 5 ms tick word.
// An enabled tick runs through the gain, multiply, clamp, load, divide and pulse states to its
// result; a disabled tick goes from the gain state to its result. QW = bits of 255*TICKS_PER_SECOND.
// A new tick is taken only once the last result is issued, which waits while the output slot is full;
// the divider in hpc_mdu retires one quotient bit per cycle, QW bits for an enabled tick.
// Synchronous active-high reset: gain 25, counters 0, registers 0,0,25,20,10.
module heater_time_proportional_control import hpc_pkg::*; #(
   parameter int TICKS_PER_SECOND = 200
) (
   input  logic clock,
   input  logic reset,
   hpc_req_if.sink   req_chan,
   hpc_rsp_if.source rsp_chan,
   hpc_csr_if.sink   csr_chan
);

   localparam int TKW  = $clog2(TICKS_PER_SECOND);
   localparam int TW   = $clog2(TICKS_PER_SECOND + 1);
   localparam int MBW  = (TW > GAIN_W) ? TW : GAIN_W;
   localparam int PW   = MAW + MBW;
   localparam int QW   = $clog2(255 * TICKS_PER_SECOND + 1);
   localparam int QCW  = $clog2(QW + 1);
   localparam int LIMW = CFG_W + TW;
   localparam int CXW  = (LIMW > PULSE_W) ? LIMW : PULSE_W + 1;
   localparam int QXW  = (QW > PULSE_W) ? QW : PULSE_W + 1;
   localparam int PULSE_LIM = PULSE_STEP_SECONDS * TICKS_PER_SECOND;

   state_type state_ff, state_in;

   logic [TKW-1:0]     tick_ff, tick_in;
   logic [SEC_W-1:0]   sec_ff, sec_in;
   logic [PULSE_W-1:0] cnt_ff, cnt_in;
   logic [PULSE_W-1:0] pulse_ff, pulse_in;
   logic [GAIN_W-1:0]  gain_ff, gain_in;
   logic [CFG_W-1:0]   sp_ff, sp_in;
   logic [CFG_W-1:0]   off_ff, off_in;
   logic [CFG_W-1:0]   fb_ff, fb_in;
   logic [CFG_W-1:0]   cs_ff, cs_in;
   logic               active_ff, active_in;
   logic [QCW-1:0]     div_cnt_ff, div_cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic signed [TEMP_W-1:0] temp_ff, temp_in;
   logic signed [RISE_W-1:0] rise_ff, rise_in;
   logic signed [E_W-1:0]    e_ff, e_in;
   logic [D_W-1:0]           d_ff, d_in;
   logic                     heater_ff, heater_in;
   logic [PULSE_W-1:0]       on_ticks_ff, on_ticks_in;
   logic [GAIN_W-1:0]        gain_now_ff, gain_now_in;

   logic                     req_acc;
   logic [TKW:0]             tick_inc;
   logic [CFG_W:0]           sum_c;
   logic signed [E_W-1:0]    e_calc;
   logic                     step_ok;
   logic [GAIN_W:0]          gain_inc;
   logic [GAIN_W-1:0]        gain_new;
   logic [D_W-1:0]           div10;
   logic [LIMW-1:0]          limit;
   logic                     wrap;
   logic [E_W-2:0]           epos;
   logic [QXW-1:0]           quo_x;
   logic                     slot_free;

   mdu_op_type     op;
   logic [MAW-1:0] mdu_a;
   logic [MBW-1:0] mdu_b;
   logic [PW-1:0]  prod;
   logic [QW-1:0]  quo;

   hpc_mdu #(
      .MBW (MBW),
      .QW  (QW),
      .RW  (D_W)
   ) u_mdu (
      .clock   (clock),
      .op      (op),
      .a       (mdu_a),
      .b       (mdu_b),
      .divisor (div10),
      .prod    (prod),
      .quo     (quo)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;
   assign req_acc        = req_chan.valid && req_chan.ready;
   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.heater_on = heater_ff;
   assign rsp_chan.on_ticks  = on_ticks_ff;
   assign rsp_chan.gain_now  = gain_now_ff;

   // datapath helpers
   always_comb begin
      tick_inc = {1'b0, tick_ff} + (TKW+1)'(1);
      sum_c    = {1'b0, off_ff} + {1'b0, sp_ff};
      e_calc   = signed'(E_W'({sum_c, 3'b000}) + E_W'({sum_c, 1'b0})) - E_W'(temp_ff);
      step_ok  = (e_calc > E_STEP_LO) && (e_calc < E_STEP_HI) && (rise_ff < RISE_STEP)
                 && ({1'b0, pulse_ff} < (PULSE_W+1)'(PULSE_LIM))
                 && (sec_ff >= GAIN_STEP_SECONDS);
      gain_inc = {1'b0, gain_ff} + GAIN_INC;
      div10    = D_W'({sp_ff, 3'b000}) + D_W'({sp_ff, 1'b0});
      limit    = LIMW'(cs_ff) * LIMW'(TICKS_PER_SECOND);
      wrap     = (CXW'(cnt_ff) >= CXW'(limit));
      // negative error gives no drive
      epos     = e_ff[E_W-1] ? '0 : e_ff[E_W-2:0];
      quo_x    = QXW'(quo);
   end

   always_comb begin
      gain_new = gain_ff;
      if (step_ok) begin
         gain_new = gain_inc[GAIN_W] ? GAIN_MAX : gain_inc[GAIN_W-1:0];
      end
      if (e_calc < E_OVERSHOOT) begin
         gain_new = fb_ff;
      end
      if (gain_new == '0) begin
         gain_new = GAIN_W'(1);
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      tick_in      = tick_ff;
      sec_in       = sec_ff;
      cnt_in       = cnt_ff;
      pulse_in     = pulse_ff;
      gain_in      = gain_ff;
      sp_in        = sp_ff;
      off_in       = off_ff;
      fb_in        = fb_ff;
      cs_in        = cs_ff;
      active_in    = active_ff;
      div_cnt_in   = div_cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      temp_in      = temp_ff;
      rise_in      = rise_ff;
      e_in         = e_ff;
      d_in         = d_ff;
      heater_in    = heater_ff;
      on_ticks_in  = on_ticks_ff;
      gain_now_in  = gain_now_ff;
      op           = MDU_HOLD;
      mdu_a        = '0;
      mdu_b        = '0;

      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               temp_in   = req_chan.temperature_tenths;
               rise_in   = req_chan.rise_tenths;
               active_in = req_chan.enable && (sp_ff != '0);
               cnt_in    = cnt_ff + PULSE_W'(1);
               if (tick_inc >= (TKW+1)'(TICKS_PER_SECOND)) begin
                  tick_in = '0;
                  if (sec_ff < SEC_MAX) begin
                     sec_in = sec_ff + SEC_W'(1);
                  end
               end else begin
                  tick_in = tick_inc[TKW-1:0];
               end
               state_in = ST_GAIN;
            end
         end
         ST_GAIN: begin
            e_in = e_calc;
            if (active_ff) begin
               gain_in = gain_new;
               if (step_ok) begin
                  sec_in = '0;
               end
               state_in = ST_MUL_EG;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_MUL_EG: begin
            op       = MDU_MUL;
            mdu_a    = MAW'(epos);
            mdu_b    = MBW'(gain_ff);
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            d_in     = (prod > PW'(div10)) ? div10 : D_W'(prod);
            state_in = ST_MUL_DC;
         end
         ST_MUL_DC: begin
            op       = MDU_MUL;
            mdu_a    = MAW'(d_ff);
            mdu_b    = MBW'(cs_ff);
            state_in = ST_MUL_DT;
         end
         ST_MUL_DT: begin
            op       = MDU_MUL;
            mdu_a    = MAW'(prod);
            mdu_b    = MBW'(TICKS_PER_SECOND);
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            op         = MDU_LOAD;
            div_cnt_in = '0;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            op         = MDU_STEP;
            div_cnt_in = div_cnt_ff + QCW'(1);
            if (div_cnt_ff == QCW'(QW - 1)) begin
               state_in = ST_PULSE;
            end
         end
         ST_PULSE: begin
            pulse_in = (quo_x > QXW'(16'hFFFF)) ? '1 : quo_x[PULSE_W-1:0];
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               heater_in    = active_ff && (cnt_ff <= pulse_ff);
               on_ticks_in  = pulse_ff;
               gain_now_in  = gain_ff;
               if (wrap) begin
                  cnt_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_chan.valid && csr_chan.ready) begin
         case (csr_chan.index)
            CSR_SETPOINT:      sp_in  = csr_chan.data;
            CSR_OFFSET:        off_in = csr_chan.data;
            CSR_INITIAL_GAIN:  gain_in = csr_chan.data;
            CSR_FALLBACK_GAIN: fb_in  = csr_chan.data;
            CSR_CYCLE_SECONDS: cs_in  = csr_chan.data;
            default:           sp_in  = sp_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tick_ff      <= '0;
         sec_ff       <= '0;
         cnt_ff       <= '0;
         pulse_ff     <= '0;
         gain_ff      <= GAIN_RESET;
         sp_ff        <= '0;
         off_ff       <= '0;
         fb_ff        <= FALLBACK_RESET;
         cs_ff        <= CYCLE_RESET;
         active_ff    <= 1'b0;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         sec_ff       <= sec_in;
         cnt_ff       <= cnt_in;
         pulse_ff     <= pulse_in;
         gain_ff      <= gain_in;
         sp_ff        <= sp_in;
         off_ff       <= off_in;
         fb_ff        <= fb_in;
         cs_ff        <= cs_in;
         active_ff    <= active_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      temp_ff     <= temp_in;
      rise_ff     <= rise_in;
      e_ff        <= e_in;
      d_ff        <= d_in;
      heater_ff   <= heater_in;
      on_ticks_ff <= on_ticks_in;
      gain_now_ff <= gain_now_in;
   end

`ifndef NO_ASSERTIONS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_chan.ready)
      else $error("request taken while a tick is in progress");

   a_gain_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN) |-> (!active_ff || (gain_ff != '0)))
      else $error("active tick finished with zero gain");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (div_cnt_ff < QCW'(QW)))
      else $error("divider step count overran");

   a_counter_wrapped: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FIN) && slot_free) |=>
      ((cnt_ff == '0) || (CXW'(cnt_ff) < CXW'(limit))))
      else $error("cycle counter not wrapped at cycle length");
`endif

endmodule

### src/hpc_mdu.sv
// Shared multiply and restoring-divide unit, one quotient bit per step.
module hpc_mdu import hpc_pkg::*; #(
   parameter int MBW = 8,
   parameter int QW  = 16,
   parameter int RW  = 12
) (
   input  logic               clock,
   input  mdu_op_type         op,
   input  logic [MAW-1:0]     a,
   input  logic [MBW-1:0]     b,
   input  logic [RW-1:0]      divisor,
   output logic [MAW+MBW-1:0] prod,
   output logic [QW-1:0]      quo
);

   localparam int PW = MAW + MBW;

   logic [PW-1:0] acc_ff, acc_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic [QW-1:0] quo_ff, quo_in;
   logic [RW:0]   part;
   logic [RW:0]   diff;
   logic          ge;

   always_comb begin
      acc_in = acc_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      part   = {rem_ff, quo_ff[QW-1]};
      diff   = part - {1'b0, divisor};
      ge     = (part >= {1'b0, divisor});
      case (op)
         MDU_MUL: begin
            acc_in = PW'(a) * PW'(b);
         end
         MDU_LOAD: begin
            // high part is below the divisor since the drive was clamped
            rem_in = RW'(acc_ff >> QW);
            quo_in = acc_ff[QW-1:0];
         end
         MDU_STEP: begin
            rem_in = ge ? diff[RW-1:0] : part[RW-1:0];
            quo_in = {quo_ff[QW-2:0], ge};
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign prod = acc_ff;
   assign quo  = quo_ff;

endmodule

### dv/heater_time_proportional_control_tb.sv
// Self-checking testbench for the heater time-proportional controller.
module heater_time_proportional_control_tb;
   import hpc_pkg::*;

   localparam int TICKS_PER_SEC = 200;
   localparam int STEP_SECONDS  = 20;
   localparam int SECONDS_CAP   = 31;
   localparam int PULSE_CAP_SEC = 9;
   localparam int NUM_PHASES    = 12;
   localparam int PHASE_ITEMS   = 52;
   localparam int FILLER_TICKS  = 10;
   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int TEMP_MAX      = (1 << (TEMP_W - 1)) - 1;
   localparam int TEMP_MIN      = -(1 << (TEMP_W - 1));

   typedef struct packed {
      logic signed [TEMP_W-1:0] temperature;
      logic signed [RISE_W-1:0] rise;
      logic                     enable;
   } tick_word_type;

   typedef struct packed {
      logic               heater_on;
      logic [PULSE_W-1:0] on_ticks;
      logic [GAIN_W-1:0]  gain_now;
   } drive_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hpc_req_if req_chan ();
   hpc_rsp_if rsp_chan ();
   hpc_csr_if csr_chan ();

   heater_time_proportional_control #(
      .TICKS_PER_SECOND(TICKS_PER_SEC)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_chan(csr_chan)
   );

   always #5 clock = ~clock;

   // register mirror
   int cfg_setpoint = 0;
   int cfg_offset   = 0;
   int cfg_init     = 25;
   int cfg_fallback = 20;
   int cfg_cycle    = 10;
   // controller state mirror
   int gain_q       = 25;
   int tick_in_sec  = 0;
   int secs_since   = 0;
   int cycle_pos    = 0;
   int pulse_q      = 0;

   tick_word_type  tick_backlog[$];
   drive_word_type expected_drive[$];
   tick_word_type  held_tick;
   drive_word_type want;
   int             send_idle_pct = 30;
   int             recv_idle_pct = 83;
   int             error_count   = 0;
   int             cycle_count   = 0;

   function automatic drive_word_type control_tick(tick_word_type w);
      int             err;
      longint         drive;
      longint         on_time;
      drive_word_type r;
      r.heater_on = 1'b0;
      tick_in_sec++;
      if (tick_in_sec >= TICKS_PER_SEC) begin
         tick_in_sec = 0;
         if (secs_since < SECONDS_CAP) secs_since++;
      end
      cycle_pos = (cycle_pos + 1) % 65536;
      if (w.enable && cfg_setpoint != 0) begin
         err = 10 * (cfg_offset + cfg_setpoint) - int'(w.temperature);
         if (err > 9 && err < 150 && int'(w.rise) < 3 &&
             pulse_q < PULSE_CAP_SEC * TICKS_PER_SEC && secs_since >= STEP_SECONDS) begin
            secs_since = 0;
            gain_q = (gain_q + 2 > 255) ? 255 : gain_q + 2;
         end
         if (err < -3) gain_q = cfg_fallback;
         if (gain_q < 1) gain_q = 1;
         drive = (err > 0) ? longint'(err) * gain_q : 0;
         if (drive > 10 * cfg_setpoint) drive = 10 * cfg_setpoint;
         on_time = drive * cfg_cycle * TICKS_PER_SEC / (10 * cfg_setpoint);
         pulse_q = (on_time > 65535) ? 65535 : int'(on_time);
         r.heater_on = (cycle_pos <= pulse_q);
      end
      if (cycle_pos >= cfg_cycle * TICKS_PER_SEC) cycle_pos = 0;
      r.on_ticks = pulse_q[PULSE_W-1:0];
      r.gain_now = gain_q[GAIN_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      error_count++;
   endtask

   // tick driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) expected_drive.push_back(control_tick(held_tick));
         if (!req_chan.valid || req_chan.ready) begin
            if (tick_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               held_tick = tick_backlog.pop_front();
               req_chan.valid              <= 1'b1;
               req_chan.temperature_tenths <= held_tick.temperature;
               req_chan.rise_tenths        <= held_tick.rise;
               req_chan.enable             <= held_tick.enable;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_drive.size() == 0) begin
               report_mismatch("result word with nothing pending");
            end else begin
               want = expected_drive.pop_front();
               if (rsp_chan.heater_on !== want.heater_on)
                  report_mismatch($sformatf("heater_on got %0b want %0b",
                                            rsp_chan.heater_on, want.heater_on));
               if (rsp_chan.on_ticks !== want.on_ticks)
                  report_mismatch($sformatf("on_ticks got %0d want %0d",
                                            rsp_chan.on_ticks, want.on_ticks));
               if (rsp_chan.gain_now !== want.gain_now)
                  report_mismatch($sformatf("gain_now got %0d want %0d",
                                            rsp_chan.gain_now, want.gain_now));
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("status: fail");
         $finish;
      end
   end

   task automatic write_reg(csr_index_type idx, int val);
      @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= val[CFG_W-1:0];
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      case (idx)
         CSR_SETPOINT:      cfg_setpoint = val;
         CSR_OFFSET:        cfg_offset = val;
         CSR_INITIAL_GAIN: begin
            cfg_init = val;
            gain_q   = val;
         end
         CSR_FALLBACK_GAIN: cfg_fallback = val;
         CSR_CYCLE_SECONDS: cfg_cycle = val;
         default: ;
      endcase
   endtask

   // settle on a falling edge so queue reads never race the clocked blocks
   task automatic wait_drained();
      do @(negedge clock);
      while (tick_backlog.size() != 0 || req_chan.valid || expected_drive.size() != 0);
   endtask

   function automatic void push_raw(int temp, int rise, bit en);
      tick_word_type w;
      w.temperature = temp[TEMP_W-1:0];
      w.rise        = rise[RISE_W-1:0];
      w.enable      = en;
      tick_backlog.push_back(w);
   endfunction

   // tick whose error against the current target is err
   function automatic void push_near(int err, int rise, bit en);
      int temp;
      temp = 10 * (cfg_offset + cfg_setpoint) - err;
      if (temp > TEMP_MAX) temp = TEMP_MAX;
      if (temp < TEMP_MIN) temp = TEMP_MIN;
      push_raw(temp, rise, en);
   endfunction

   function automatic void push_noise(bit force_off);
      push_raw($urandom(), $urandom(), force_off ? 1'b0 : $urandom_range(1));
   endfunction

   task automatic run_phase(int p);
      int sp, off, ig, fb, cs;
      case (p % 4)
         1: begin
            sp = $urandom_range(1, 3); off = 0; ig = 0; fb = 0; cs = 0;
         end
         3: begin
            sp = 255; off = 255; ig = 255; fb = 255; cs = 255;
         end
         default: begin
            sp = $urandom_range(1, 180);
            off = $urandom_range(0, 20);
            ig = ($urandom_range(3) == 0) ? $urandom_range(250, 255) : $urandom_range(255);
            fb = $urandom_range(255);
            cs = ($urandom_range(5) == 0) ? $urandom_range(5, 255) : $urandom_range(1, 4);
         end
      endcase
      wait_drained();
      write_reg(CSR_SETPOINT, sp);
      write_reg(CSR_OFFSET, off);
      write_reg(CSR_FALLBACK_GAIN, fb);
      write_reg(CSR_CYCLE_SECONDS, cs);
      // sometimes keep the adapted gain across phases
      if (p % 4 != 2 || $urandom_range(1)) write_reg(CSR_INITIAL_GAIN, ig);
      @(negedge clock);
      if (p < NUM_PHASES / 3) begin
         send_idle_pct = 30; recv_idle_pct = 83;
      end else if (p < 2 * NUM_PHASES / 3) begin
         send_idle_pct = 83; recv_idle_pct = 30;
      end else begin
         send_idle_pct = 0; recv_idle_pct = 0;
      end
      // disabled ticks advance the timers and leave gain alone
      if (p % 2 == 0)
         for (int i = 0; i < FILLER_TICKS; i++) push_noise(1'b1);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         if ($urandom_range(3) == 0)
            push_noise(1'b0);
         else
            push_near(int'($urandom_range(220)) - 20, int'($urandom_range(12)) - 8,
                      $urandom_range(7) != 0);
      end
   endtask

   initial begin
      req_chan.valid              = 1'b0;
      req_chan.temperature_tenths = '0;
      req_chan.rise_tenths        = '0;
      req_chan.enable             = 1'b0;
      rsp_chan.ready              = 1'b0;
      csr_chan.valid              = 1'b0;
      csr_chan.index              = CSR_SETPOINT;
      csr_chan.data               = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // zero setpoint after reset keeps the heater off
      for (int i = 0; i < 40; i++) push_noise(1'b0);
      wait_drained();

      write_reg(CSR_SETPOINT, 100);
      write_reg(CSR_OFFSET, 5);
      write_reg(CSR_INITIAL_GAIN, 25);
      write_reg(CSR_FALLBACK_GAIN, 20);
      write_reg(CSR_CYCLE_SECONDS, 1);
      @(negedge clock);
      push_near(10, 0, 1);      // lower edge of the step window
      push_near(9, 0, 1);
      push_near(149, 0, 1);
      push_near(150, 0, 1);
      push_near(-3, 0, 1);
      push_near(-4, 0, 1);      // overshoot reload
      push_near(0, 0, 1);       // zero pulse
      push_near(30, 2, 1);
      push_near(30, 3, 1);
      push_near(500, 0, 1);
      push_near(12, 0, 0);
      push_raw(TEMP_MIN, -1024, 1);
      push_raw(TEMP_MAX, 1023, 1);
      push_raw(TEMP_MIN, 1023, 0);
      push_raw(TEMP_MAX, -1024, 0);
      push_raw(0, 0, 1);

      for (int p = 0; p < NUM_PHASES; p++) run_phase(p);

      wait_drained();
      repeat (40) @(posedge clock);
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

### sim.f
src/hpc_pkg.sv
src/hpc_ifs.sv
src/hpc_mdu.sv
src/heater_time_proportional_control.sv
dv/heater_time_proportional_control_tb.sv
